// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, quiet while reset is held.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== hdl/rhtt_pkg.sv =====
package rhtt_pkg;

    // Default CORDIC depth and arctangent table length
    localparam int P_CORDIC_STAGES = 14;
    localparam int P_ATAN_LEN      = 24;

    // Field and datapath widths
    localparam int P_COORD_W = 32;
    localparam int P_DIFF_W  = 33;
    localparam int P_XY_W    = 36;
    localparam int P_ANGLE_W = 15;
    localparam int P_HEAD_W  = 16;
    localparam int P_Z_W     = 21;
    localparam int P_SUM_W   = 22;
    localparam int P_RND_W   = 18;

    // Angle constants: true pi and 3.142 in Q.16, 1.571 and 3.142 in Q4.12
    localparam logic signed [P_Z_W-1:0]     P_TRUE_PI_Q16 = 21'sd205887;
    localparam logic signed [P_Z_W-1:0]     P_PI_Q16      = 21'sd205914;
    localparam logic signed [P_ANGLE_W-1:0] P_HALF_PI_Q12 = 15'sd6435;
    localparam logic signed [P_HEAD_W-1:0]  P_PI_Q12      = 16'sd12870;

    // Output clamp bounds at the rounded width
    localparam logic signed [P_RND_W-1:0] P_HEAD_MAX = 18'sd32767;
    localparam logic signed [P_RND_W-1:0] P_HEAD_MIN = -18'sd32768;

    // Sideband that travels with each beat through the CORDIC stages
    typedef struct packed {
        logic                        plus;
        logic                        zero;
        logic signed [P_ANGLE_W-1:0] angle;
    } t_side;

    // round(atan(2^-i) * 65536)
    function automatic logic [P_Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic [P_Z_W-1:0] val;
        unique case (idx)
            5'd0:    val = 21'd51472;
            5'd1:    val = 21'd30386;
            5'd2:    val = 21'd16055;
            5'd3:    val = 21'd8150;
            5'd4:    val = 21'd4091;
            5'd5:    val = 21'd2047;
            5'd6:    val = 21'd1024;
            5'd7:    val = 21'd512;
            5'd8:    val = 21'd256;
            5'd9:    val = 21'd128;
            5'd10:   val = 21'd64;
            5'd11:   val = 21'd32;
            5'd12:   val = 21'd16;
            5'd13:   val = 21'd8;
            5'd14:   val = 21'd4;
            5'd15:   val = 21'd2;
            5'd16:   val = 21'd1;
            default: val = 21'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/relative_heading_to_target_top.sv =====
// A start beat passes the difference register, the pre-rotation register, one register
// per CORDIC micro-rotation and the output register before o_valid strobes the result.
// Throughput: one item per cycle; busy stays low. One CORDIC micro-rotation per
// pipeline stage sets the depth. The receiver cannot stall.
// Reset (synchronous, active low) clears the valid bits only; in-flight beats drop.
module relative_heading_to_target_top #(
    parameter int CORDIC_STAGES = rhtt_pkg::P_CORDIC_STAGES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [rhtt_pkg::P_COORD_W-1:0]  i_target_x,
    input  logic signed [rhtt_pkg::P_COORD_W-1:0]  i_target_y,
    input  logic signed [rhtt_pkg::P_COORD_W-1:0]  i_robot_x,
    input  logic signed [rhtt_pkg::P_COORD_W-1:0]  i_robot_y,
    input  logic signed [rhtt_pkg::P_ANGLE_W-1:0]  i_robot_angle,
    output logic                                   o_valid,
    output logic signed [rhtt_pkg::P_HEAD_W-1:0]   o_relative_heading
);
    import rhtt_pkg::*;

    localparam int XY_EXT = P_XY_W - P_DIFF_W;
    localparam int ANG_EXT = P_SUM_W - P_ANGLE_W - 4;

    // Difference stage
    logic                       r_d_vld;
    logic signed [P_DIFF_W-1:0] r_dx, r_dy;
    logic signed [P_ANGLE_W-1:0] r_d_angle;

    // CORDIC pipeline: entry k feeds micro-rotation k
    logic                     r_vld  [CORDIC_STAGES+1];
    logic signed [P_XY_W-1:0] r_x    [CORDIC_STAGES+1];
    logic signed [P_XY_W-1:0] r_y    [CORDIC_STAGES+1];
    logic signed [P_Z_W-1:0]  r_z    [CORDIC_STAGES+1];
    t_side                    r_side [CORDIC_STAGES+1];

    // Pre-rotation next values
    logic                     n_neg;
    logic signed [P_XY_W-1:0] n_dx_ext, n_dy_ext, n_x0, n_y0;
    logic signed [P_Z_W-1:0]  n_z0;
    t_side                    n_side0;

    // Output stage
    logic signed [P_Z_W-1:0]   n_b;
    logic signed [P_SUM_W-1:0] n_sum;
    logic signed [P_RND_W-1:0] n_rnd;
    logic signed [P_HEAD_W-1:0] n_head;
    logic                      r_o_vld;
    logic signed [P_HEAD_W-1:0] r_o_head;

    // Never stall: one beat enters every cycle
    assign busy = 1'b0;

    // Form exact 33-bit differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx      <= $signed({i_robot_x[P_COORD_W-1], i_robot_x})
                   - $signed({i_target_x[P_COORD_W-1], i_target_x});
        r_dy      <= $signed({i_robot_y[P_COORD_W-1], i_robot_y})
                   - $signed({i_target_y[P_COORD_W-1], i_target_y});
        r_d_angle <= i_robot_angle;
    end

    // Fold left half-plane into the right one, pick the +-pi correction
    always_comb begin
        n_neg    = r_dx[P_DIFF_W-1];
        n_dx_ext = $signed({{XY_EXT{r_dx[P_DIFF_W-1]}}, r_dx});
        n_dy_ext = $signed({{XY_EXT{r_dy[P_DIFF_W-1]}}, r_dy});
        n_x0     = n_neg ? -n_dx_ext : n_dx_ext;
        n_y0     = n_neg ? -n_dy_ext : n_dy_ext;
        if (!n_neg) begin
            n_z0 = '0;
        end else if (r_dy[P_DIFF_W-1]) begin
            n_z0 = -P_TRUE_PI_Q16;
        end else begin
            n_z0 = P_TRUE_PI_Q16;
        end
        n_side0.zero  = (r_dx == '0) && (r_dy == '0);
        n_side0.angle = r_d_angle;
        priority if (!r_dy[P_DIFF_W-1] && !n_neg) begin
            n_side0.plus = (r_d_angle <= -P_HALF_PI_Q12);
        end else if (!r_dy[P_DIFF_W-1]) begin
            n_side0.plus = 1'b0;
        end else if (!n_neg) begin
            n_side0.plus = (r_d_angle < P_HALF_PI_Q12);
        end else begin
            n_side0.plus = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_z[0]    <= n_z0;
        r_side[0] <= n_side0;
    end

    // One vectoring micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        logic signed [P_XY_W-1:0] w_xs, w_ys;
        logic signed [P_Z_W-1:0]  w_atan;
        logic signed [P_XY_W-1:0] n_x, n_y;
        logic signed [P_Z_W-1:0]  n_z;

        assign w_xs   = r_x[k] >>> k;
        assign w_ys   = r_y[k] >>> k;
        assign w_atan = $signed(atan_q16(5'(k)));

        // Rotate toward the x axis
        always_comb begin
            if (!r_y[k][P_XY_W-1]) begin
                n_x = r_x[k] + w_ys;
                n_y = r_y[k] - w_xs;
                n_z = r_z[k] + w_atan;
            end else begin
                n_x = r_x[k] - w_ys;
                n_y = r_y[k] + w_xs;
                n_z = r_z[k] - w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k+1]    <= n_x;
            r_y[k+1]    <= n_y;
            r_z[k+1]    <= n_z;
            r_side[k+1] <= r_side[k];
        end
    end

    // Add robot angle and correction, round to Q4.12, clamp
    always_comb begin
        n_b   = r_side[CORDIC_STAGES].zero ? '0 : r_z[CORDIC_STAGES];
        n_sum = $signed({n_b[P_Z_W-1], n_b})
              + $signed({{ANG_EXT{r_side[CORDIC_STAGES].angle[P_ANGLE_W-1]}},
                         r_side[CORDIC_STAGES].angle, 4'b0000})
              + (r_side[CORDIC_STAGES].plus ? $signed({P_PI_Q16[P_Z_W-1], P_PI_Q16})
                                            : -$signed({P_PI_Q16[P_Z_W-1], P_PI_Q16}))
              + P_SUM_W'(8);
        n_rnd = n_sum[P_SUM_W-1:4];
        if (n_rnd > P_HEAD_MAX) begin
            n_head = P_HEAD_MAX[P_HEAD_W-1:0];
        end else if (n_rnd < P_HEAD_MIN) begin
            n_head = P_HEAD_MIN[P_HEAD_W-1:0];
        end else begin
            n_head = n_rnd[P_HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_head <= n_head;
    end

    assign o_valid            = r_o_vld;
    assign o_relative_heading = r_o_head;

endmodule

// ===== hdl/rhtt_checker.sv =====
`include "assert_macros.svh"

module rhtt_checker #(
    parameter int CORDIC_STAGES = rhtt_pkg::P_CORDIC_STAGES
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic signed [rhtt_pkg::P_COORD_W-1:0] i_target_x,
    input logic signed [rhtt_pkg::P_COORD_W-1:0] i_target_y,
    input logic signed [rhtt_pkg::P_COORD_W-1:0] i_robot_x,
    input logic signed [rhtt_pkg::P_COORD_W-1:0] i_robot_y,
    input logic signed [rhtt_pkg::P_ANGLE_W-1:0] i_robot_angle,
    input logic                                  o_valid,
    input logic signed [rhtt_pkg::P_HEAD_W-1:0]  o_relative_heading
);
    import rhtt_pkg::*;

    localparam int LAT   = CORDIC_STAGES + 3;
    localparam int CNT_W = $clog2(LAT + 1);

    logic                       w_take;
    logic                       w_zero_hit;
    logic signed [P_HEAD_W-1:0] w_angle_ext;
    logic signed [P_HEAD_W-1:0] w_zero_ref;
    logic [CNT_W-1:0]           r_run_cnt;

    assign w_take      = start && !busy;
    assign w_zero_hit  = w_take && (i_robot_x == i_target_x) && (i_robot_y == i_target_y);
    assign w_angle_ext = $signed({i_robot_angle[P_ANGLE_W-1], i_robot_angle});
    assign w_zero_ref  = (i_robot_angle <= -P_HALF_PI_Q12) ? w_angle_ext + P_PI_Q12
                                                          : w_angle_ext - P_PI_Q12;

    // Count edges since reset was last held, saturate at the latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt <= '0;
        end else if (r_run_cnt != CNT_W'(LAT)) begin
            r_run_cnt <= r_run_cnt + 1'b1;
        end
    end

    `ASSERT_ALWAYS(a_never_busy, !busy, "busy raised on a never-stalling pipeline")

    `ASSERT_RST(a_no_phantom, o_valid |-> $past(w_take, LAT), "result beat without a start beat")

    `ASSERT_RST(a_no_loss, (r_run_cnt == CNT_W'(LAT)) && $past(w_take, LAT) |-> o_valid, "start beat lost in the pipeline")

    `ASSERT_RST(a_same_point, o_valid && $past(w_zero_hit, LAT) |-> o_relative_heading == $past(w_zero_ref, LAT), "wrong heading for coincident robot and target")

endmodule

bind relative_heading_to_target_top rhtt_checker #(
    .CORDIC_STAGES(CORDIC_STAGES)
) u_rhtt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .i_target_x         (i_target_x),
    .i_target_y         (i_target_y),
    .i_robot_x          (i_robot_x),
    .i_robot_y          (i_robot_y),
    .i_robot_angle      (i_robot_angle),
    .o_valid            (o_valid),
    .o_relative_heading (o_relative_heading)
);

// ===== verif/relative_heading_to_target_top_tb.sv =====
module relative_heading_to_target_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rhtt_pkg::*;

    localparam int STAGES      = P_CORDIC_STAGES;
    localparam int LATENCY     = STAGES + 3;
    localparam int ATAN_ROWS   = P_ATAN_LEN;
    localparam int RESET_TICKS = 5;

    // Angle constants in Q.16, and the quarter-turn test scaled by 1000 in Q4.12
    localparam longint TRUE_PI_Q16     = 205887;
    localparam longint PI_3142_Q16     = 205914;
    localparam longint HALF_PI_X1000   = 6434816;

    localparam logic signed [P_COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [P_COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [P_ANGLE_W-1:0] ANGLE_MAX = 15'sd12870;
    localparam logic signed [P_ANGLE_W-1:0] ANGLE_MIN = -15'sd12870;
    localparam logic signed [P_ANGLE_W-1:0] ANGLE_TOP = 15'sh3fff;
    localparam logic signed [P_ANGLE_W-1:0] ANGLE_BOT = 15'sh4000;
    localparam logic signed [P_ANGLE_W-1:0] QUARTER   = 15'sd6435;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic signed [P_COORD_W-1:0]   i_target_x;
    logic signed [P_COORD_W-1:0]   i_target_y;
    logic signed [P_COORD_W-1:0]   i_robot_x;
    logic signed [P_COORD_W-1:0]   i_robot_y;
    logic signed [P_ANGLE_W-1:0]   i_robot_angle;
    logic                          o_valid;
    logic signed [P_HEAD_W-1:0]    o_relative_heading;

    // round(atan(2^-i) * 65536) per micro-rotation
    longint arctan_step_q16 [ATAN_ROWS] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    logic signed [P_HEAD_W-1:0] pending_headings [$];
    logic signed [P_HEAD_W-1:0] want_heading;
    int                         mismatches;
    int                         positions_sent;
    int                         headings_seen;

    relative_heading_to_target_top #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_target_x         (i_target_x),
        .i_target_y         (i_target_y),
        .i_robot_x          (i_robot_x),
        .i_robot_y          (i_robot_y),
        .i_robot_angle      (i_robot_angle),
        .o_valid            (o_valid),
        .o_relative_heading (o_relative_heading)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Expected heading: 33-bit differences, CORDIC bearing, +-3.142 fold, round, clamp
    function automatic logic signed [P_HEAD_W-1:0] predict_heading(
        input logic signed [P_COORD_W-1:0] tx,
        input logic signed [P_COORD_W-1:0] ty,
        input logic signed [P_COORD_W-1:0] rx,
        input logic signed [P_COORD_W-1:0] ry,
        input logic signed [P_ANGLE_W-1:0] ang
    );
        longint dx, dy, x, y, z, xs, ys, p, s, r;
        bit     add_pi;
        int     i;
        dx = longint'(rx) - longint'(tx);
        dy = longint'(ry) - longint'(ty);
        p  = longint'(ang);
        z  = 0;
        if (dx != 0 || dy != 0) begin
            x = dx;
            y = dy;
            // fold the left half-plane onto the right, bearing starts at +-pi
            if (dx < 0) begin
                x = -dx;
                y = -dy;
                z = (dy >= 0) ? TRUE_PI_Q16 : -TRUE_PI_Q16;
            end
            for (i = 0; i < STAGES && i < ATAN_ROWS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + arctan_step_q16[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - arctan_step_q16[i];
                end
            end
        end
        if (dy >= 0)
            add_pi = (dx >= 0) ? (p * 1000 <= -HALF_PI_X1000) : 1'b0;
        else
            add_pi = (dx >= 0) ? !(p * 1000 > HALF_PI_X1000) : 1'b1;
        s = z + p * 16 + (add_pi ? PI_3142_Q16 : -PI_3142_Q16);
        r = (s + 8) >>> 4;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[P_HEAD_W-1:0];
    endfunction

    // Present one position beat and hold it until accepted
    task automatic send_position(
        input logic signed [P_COORD_W-1:0] tx,
        input logic signed [P_COORD_W-1:0] ty,
        input logic signed [P_COORD_W-1:0] rx,
        input logic signed [P_COORD_W-1:0] ry,
        input logic signed [P_ANGLE_W-1:0] ang
    );
        start         <= 1'b1;
        i_target_x    <= tx;
        i_target_y    <= ty;
        i_robot_x     <= rx;
        i_robot_y     <= ry;
        i_robot_angle <= ang;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_headings = {pending_headings, predict_heading(tx, ty, rx, ry, ang)};
        positions_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Coincident points, axes, and differences at the full 33-bit reach
    task automatic test_corner_positions();
        send_position(0, 0, 0, 0, 15'sd0);
        send_position(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, -QUARTER);
        send_position(1, 7, 0, 7, 15'sd0);
        send_position(COORD_MAX, 5, COORD_MIN, 5, 15'sd1000);
        send_position(COORD_MIN, -3, COORD_MAX, -3, -15'sd1000);
        send_position(12, COORD_MIN, 12, COORD_MAX, 15'sd0);
        send_position(-12, COORD_MAX, -12, COORD_MIN, 15'sd0);
        send_position(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 15'sd0);
        send_position(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 15'sd0);
        send_position(0, 0, 0, -1, 15'sd0);
        send_position(0, 0, -1, 1, 15'sd0);
    endtask

    // Sign choice right at the +-pi/2 bounds on the robot angle
    task automatic test_angle_thresholds();
        send_position(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, QUARTER);
        send_position(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, QUARTER - 15'sd1);
        send_position(0, 0, 1, 1, -QUARTER);
        send_position(0, 0, 1, 1, -QUARTER + 15'sd1);
        send_position(0, 0, 1, 1, ANGLE_MIN);
        send_position(0, 0, 5, -9, ANGLE_MAX);
    endtask

    // Nominal extremes and angles outside +-pi in every quadrant
    task automatic test_angle_extremes();
        send_position(100, 100, -100, -100, ANGLE_MAX);
        send_position(100, -100, -100, 100, ANGLE_MIN);
        send_position(100, 100, -100, -100, ANGLE_TOP);
        send_position(100, -100, -100, 100, ANGLE_BOT);
        send_position(-100, -100, 100, 100, ANGLE_BOT);
        send_position(-100, 100, 100, -100, ANGLE_TOP);
    endtask

    // Random positions of several shapes; the sender idles idle_pct of the time
    task automatic test_random_positions(input int count, input int idle_pct);
        logic signed [P_COORD_W-1:0] tx, ty, rx, ry;
        logic signed [P_ANGLE_W-1:0] ang;
        int                          shape, pick;
        for (int n = 0; n < count; n++) begin
            tx    = $urandom;
            ty    = $urandom;
            rx    = $urandom;
            ry    = $urandom;
            shape = $urandom_range(9);
            case (shape)
                // neighbors: tiny differences stress the last stages
                4, 5: begin
                    rx = tx + $urandom_range(128) - 64;
                    ry = ty + $urandom_range(128) - 64;
                end
                // on an axis through the target
                6: begin
                    if ($urandom_range(1))
                        rx = tx;
                    else
                        ry = ty;
                end
                7: begin
                    rx = tx + $urandom_range(2097152) - 1048576;
                    ry = ty + $urandom_range(2097152) - 1048576;
                end
                default: ;
            endcase
            pick = $urandom_range(31);
            if (pick == 0)
                ang = P_ANGLE_W'($urandom);
            else if (pick < 6 || shape >= 8)
                ang = P_ANGLE_W'((($urandom_range(1) != 0) ? QUARTER : -QUARTER)
                                 + $urandom_range(6) - 3);
            else
                ang = P_ANGLE_W'($urandom_range(25740) - 12870);
            if ($urandom_range(99) < idle_pct)
                idle_sender($urandom_range(1, 4));
            send_position(tx, ty, rx, ry, ang);
        end
    endtask

    // Compare each result beat with the oldest expected heading
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            headings_seen++;
            if (pending_headings.size() == 0) begin
                mismatches++;
                $display("%0t: heading %0d with none expected", $time, o_relative_heading);
            end else begin
                want_heading = pending_headings.pop_front();
                if (o_relative_heading !== want_heading) begin
                    mismatches++;
                    $display("%0t: heading mismatch, expected %0d actual %0d",
                             $time, want_heading, o_relative_heading);
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        mismatches     = 0;
        positions_sent = 0;
        headings_seen  = 0;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_target_x    <= '0;
        i_target_y    <= '0;
        i_robot_x     <= '0;
        i_robot_y     <= '0;
        i_robot_angle <= '0;
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_positions();
        test_angle_thresholds();
        test_angle_extremes();
        test_random_positions(475, 0);
        test_random_positions(475, 52);
        test_random_positions(475, 23);
        test_random_positions(475, 0);

        // Drain the pipeline, then watch for stray beats
        start <= 1'b0;
        for (int w = 0; w < 10 * LATENCY && pending_headings.size() != 0; w++)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (pending_headings.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected headings never arrived", $time,
                     pending_headings.size());
        end

        $display("Covered %0d positions: coincident and axis points, full-range differences,",
                 positions_sent);
        $display("quarter-turn angle bounds and random beats at 0/23/52%% sender idle; %0d checked.",
                 headings_seen);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== relative_heading_to_target_top.f =====
+incdir+hdl
hdl/rhtt_pkg.sv
hdl/relative_heading_to_target_top.sv
hdl/rhtt_checker.sv
verif/relative_heading_to_target_top_tb.sv
